/* design/lowest_free_id_allocator_macros.svh */
// Assertion macros for the lowest free identifier allocator.
// Used by lowest_free_id_allocator.sv; needs clk_i and rst_ni in scope.
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define LFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFA_ASSERT_SAME(lbl, ante, cons, msg)
`define LFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/lfa_pkg.sv */
// Package of the lowest free identifier allocator: sizes, codes, item types.
// No dependencies; used by lowest_free_id_allocator.sv.
package lfa_pkg;

  localparam int ID_COUNT  = 1024;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ID_W      = $clog2(ID_COUNT);
  localparam int GID_W     = (ID_W > BIT_W) ? ID_W : BIT_W;
  localparam int FIELD_W   = 10;
  localparam int CMP_W     = ((ID_W > FIELD_W) ? ID_W : FIELD_W) + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } lfa_cmd_e;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_RELEASED  = 2'd2,
    STAT_IGNORED   = 2'd3
  } lfa_status_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_RCHK
  } lfa_state_e;

  typedef struct packed {
    lfa_cmd_e           command;
    logic [FIELD_W-1:0] release_id;
  } lfa_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted_id;
    lfa_status_e        status;
  } lfa_rsp_t;

  function automatic word_t last_mask();
    word_t m;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if ((MAP_WORDS - 1) * WORD_BITS + b < ID_COUNT) m[b] = 1'b1;
    end
    return m;
  endfunction

  localparam word_t LAST_MASK = last_mask();

  function automatic logic [FIELD_W-1:0] id_field(input logic [GID_W-1:0] v);
    logic [GID_W+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, v};
    return e[FIELD_W-1:0];
  endfunction

  function automatic logic rid_in_range(input logic [FIELD_W-1:0] rid);
    logic [CMP_W-1:0] e;
    e = CMP_W'(rid);
    return (rid != '0) && (e < CMP_W'(ID_COUNT));
  endfunction

endpackage

/* design/lfa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/lowest_free_id_allocator.sv */
// Top level of the lowest free identifier allocator: sequencer over a free bitmap.
// Depends on lfa_pkg, lfa_ram and lowest_free_id_allocator_macros.svh.
//
// Hands out identifiers 1 to ID_COUNT-1, lowest free first; identifier 0 means none.
// An item is taken when start is high and busy is low; its single result shows on
// rsp_o for one cycle with result_strobe_o and cannot be held off. After reset an
// initialising pass writes every bitmap word, marking all identifiers but 0 free,
// with busy high. An allocate checks one bitmap word per cycle through the RAM
// read port, from word 0 up and at most MAP_WORDS words, and stops at the first
// word with a free bit. A release takes its word and bit straight from the upper
// and lower bits of release_id, then reads that word and writes it back with busy
// high; if that identifier is already free it answers ignored. A release of zero or
// of an out-of-range identifier answers on the next cycle without going busy.
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator
  import lfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lfa_req_t req_i,
  output logic     result_strobe_o,
  output lfa_rsp_t rsp_o
);

  lfa_state_e         state_q, state_d;
  logic [WA_W-1:0]    word_q, word_d;
  logic [GID_W-1:0]   base_q, base_d;
  logic [BIT_W-1:0]   rem_q, rem_d;
  logic               strobe_q, strobe_d;
  lfa_rsp_t           rsp_q, rsp_d;

  logic               ram_we;
  logic [WA_W-1:0]    ram_waddr;
  word_t              ram_wdata;
  logic [WA_W-1:0]    ram_raddr;
  word_t              ram_rdata;

  logic               last_word;
  logic               scan_hit;
  logic [BIT_W-1:0]   hit_bit;
  word_t              hit_mask;
  word_t              rel_mask;
  logic               rel_free;
  logic [WA_W-1:0]    rel_word;
  logic               req_ok;
  word_t              init_val;
  logic               id_leak;

  function automatic logic [BIT_W-1:0] ffs(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  lfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy      = (state_q != ST_IDLE);
  assign last_word = (word_q == WA_W'(MAP_WORDS - 1));
  assign scan_hit  = |ram_rdata;
  assign hit_bit   = ffs(ram_rdata);
  assign hit_mask  = word_t'(1) << hit_bit;
  assign rel_mask  = word_t'(1) << rem_q;
  assign rel_free  = |(ram_rdata & rel_mask);
  assign rel_word  = WA_W'(req_i.release_id >> BIT_W);
  assign req_ok    = rid_in_range(req_i.release_id);

  always_comb begin
    init_val = '1;
    if (word_q == '0) init_val[0] = 1'b0;
    if (last_word) init_val = init_val & LAST_MASK;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (last_word) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req_i.command == CMD_ALLOC) state_d = ST_SCAN;
          else if (req_ok) state_d = ST_RCHK;
        end
      end
      ST_SCAN: begin
        if (scan_hit || last_word) state_d = ST_IDLE;
      end
      ST_RCHK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    word_d    = word_q;
    base_d    = base_q;
    rem_d     = rem_q;
    strobe_d  = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = ram_rdata;
    ram_raddr = word_q;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_val;
        word_d    = last_word ? '0 : word_q + WA_W'(1);
      end
      ST_IDLE: begin
        ram_raddr = (req_i.command == CMD_RELEASE) ? rel_word : '0;
        if (start) begin
          word_d = (req_i.command == CMD_RELEASE) ? rel_word : '0;
          base_d = '0;
          rem_d  = req_i.release_id[BIT_W-1:0];
          if (req_i.command == CMD_RELEASE && !req_ok) begin
            strobe_d         = 1'b1;
            rsp_d.granted_id = '0;
            rsp_d.status     = STAT_IGNORED;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = word_q + WA_W'(1);
        if (scan_hit) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata & ~hit_mask;
          strobe_d         = 1'b1;
          rsp_d.granted_id = id_field(base_q + GID_W'(hit_bit));
          rsp_d.status     = STAT_ALLOCATED;
        end else if (last_word) begin
          strobe_d         = 1'b1;
          rsp_d.granted_id = '0;
          rsp_d.status     = STAT_EXHAUSTED;
        end else begin
          word_d = word_q + WA_W'(1);
          base_d = base_q + GID_W'(WORD_BITS);
        end
      end
      ST_RCHK: begin
        strobe_d         = 1'b1;
        rsp_d.granted_id = '0;
        if (rel_free) begin
          rsp_d.status = STAT_IGNORED;
        end else begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata | rel_mask;
          rsp_d.status = STAT_RELEASED;
        end
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      word_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      word_q   <= word_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
    rsp_q  <= rsp_d;
  end

  assign result_strobe_o = strobe_q;
  assign rsp_o           = rsp_q;

  assign id_leak = result_strobe_o && (rsp_o.status != STAT_ALLOCATED) &&
                   (rsp_o.granted_id != '0);

  `LFA_ASSERT_SAME(a_strobe_when_idle, result_strobe_o, !busy, "result while busy")
  `LFA_ASSERT_SAME(a_no_id_unless_granted, id_leak, 1'b0, "identifier on a non-grant result")
  `LFA_ASSERT_NEXT(a_item_progresses, start && !busy, busy || result_strobe_o, "accepted item dropped")

endmodule
